>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/mrrf_pkg.sv
`timescale 1ns / 1ps

package mrrf_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;

  typedef enum logic [1:0] {
    KIND_POWER   = 2'd0,
    KIND_VOLTAGE = 2'd1,
    KIND_CURRENT = 2'd2,
    KIND_DEFAULT = 2'd3
  } kind_e;

  // Byte position within the 8-byte request, in send order.
  typedef enum logic [2:0] {
    POS_DEV     = 3'd0,
    POS_FUNC    = 3'd1,
    POS_ADDR_HI = 3'd2,
    POS_ADDR_LO = 3'd3,
    POS_CNT_HI  = 3'd4,
    POS_CNT_LO  = 3'd5,
    POS_CRC_LO  = 3'd6,
    POS_CRC_HI  = 3'd7
  } frame_pos_e;

  // Classified request handed from front to back.
  typedef struct packed {
    logic [7:0]  dev_addr;
    logic [15:0] reg_addr;
    logic [15:0] reg_count;
  } req_t;

  // One byte through CRC-16/Modbus (reflected, shift right).
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

>>> rtl/mrrf_front.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module mrrf_front
  import mrrf_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] dev_addr_i,
  input  logic [1:0] measure_kind_i,
  output logic       req_valid_o,
  input  logic       req_ready_i,
  output req_t       req_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  req_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;
  req_t            req_new;

  // Classify: measurement kind selects register address and count.
  always_comb begin
    req_new.dev_addr = dev_addr_i;
    unique case (kind_e'(measure_kind_i))
      KIND_POWER: begin
        req_new.reg_addr  = 16'h030A;
        req_new.reg_count = 16'h0001;
      end
      KIND_VOLTAGE: begin
        req_new.reg_addr  = 16'h030E;
        req_new.reg_count = 16'h0003;
      end
      KIND_CURRENT: begin
        req_new.reg_addr  = 16'h0309;
        req_new.reg_count = 16'h0001;
      end
      KIND_DEFAULT: begin
        req_new.reg_addr  = 16'h0003;
        req_new.reg_count = 16'h0001;
      end
      default: begin
        req_new.reg_addr  = 16'h0003;
        req_new.reg_count = 16'h0001;
      end
    endcase
  end

  assign in_ready_o  = (cnt_q != FullCnt);
  assign req_valid_o = (cnt_q != '0);
  assign req_o       = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = req_valid_o && req_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    priority if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= req_new;
    end
  end

  `ASSERT_ALWAYS(a_cnt_bound, clk_i, rst_ni, cnt_q <= FullCnt)
  `ASSERT_NEXT(a_cnt_up, clk_i, rst_ni, push && !pop, cnt_q == $past(cnt_q) + CntW'(1))
  `ASSERT_IMPLY(a_ptr_sync, clk_i, rst_ni, cnt_q == '0, wr_ptr_q == rd_ptr_q)

endmodule

>>> rtl/mrrf_back.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module mrrf_back
  import mrrf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  req_t       req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_data_o,
  output logic       out_last_o
);

  frame_pos_e  pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_data_q, out_data_d;
  logic        out_last_q, out_last_d;
  logic        load;
  logic [7:0]  cur_byte;
  logic [15:0] crc_base;

  // Output register frees up either when empty or when its byte transfers.
  assign load = req_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    unique case (pos_q)
      POS_DEV:     cur_byte = req_i.dev_addr;
      POS_FUNC:    cur_byte = FUNC_READ_HOLDING;
      POS_ADDR_HI: cur_byte = req_i.reg_addr[15:8];
      POS_ADDR_LO: cur_byte = req_i.reg_addr[7:0];
      POS_CNT_HI:  cur_byte = req_i.reg_count[15:8];
      POS_CNT_LO:  cur_byte = req_i.reg_count[7:0];
      POS_CRC_LO:  cur_byte = crc_q[7:0];
      POS_CRC_HI:  cur_byte = crc_q[15:8];
      default:     cur_byte = crc_q[15:8];
    endcase
  end

  assign crc_base = (pos_q == POS_DEV) ? CRC_INIT : crc_q;

  always_comb begin
    pos_d       = pos_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      out_data_d  = cur_byte;
      out_last_d  = (pos_q == POS_CRC_HI);
      pos_d       = frame_pos_e'(pos_q + 3'd1);
      // CRC covers the six body bytes only
      if (pos_q != POS_CRC_LO && pos_q != POS_CRC_HI) begin
        crc_d = crc16_byte(crc_base, cur_byte);
      end
    end
  end

  // Request leaves the queue once its final byte is loaded.
  assign req_ready_o = load && (pos_q == POS_CRC_HI);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= POS_DEV;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q      <= crc_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

  `ASSERT_NEXT(a_frame_wrap, clk_i, rst_ni, load && pos_q == POS_CRC_HI,
               pos_q == POS_DEV && out_last_q && out_valid_q)
  `ASSERT_IMPLY(a_pop_on_last, clk_i, rst_ni, req_ready_o, load && pos_q == POS_CRC_HI)
  `ASSERT_NEXT(a_mid_frame, clk_i, rst_ni, load && pos_q != POS_CRC_HI, !out_last_q)

endmodule

>>> rtl/modbus_read_request_framer.sv
`timescale 1ns / 1ps

// Modbus RTU read-holding-registers request framer.
// Input stream (s_axis): one request per transfer, carrying the slave
// address and a measurement kind (power, voltage, current, default).
// Output stream (m_axis): the 8-byte request, one byte per transfer in
// send order: address, 0x03, register address hi/lo, register count hi/lo,
// CRC-16/Modbus lo/hi. tlast marks the CRC high byte.
// The first byte of a request passes through the request queue and then the
// single byte-wide output register before it is valid. The CRC advances one
// byte for each body byte that is loaded into the output register, so it is
// ready by the time the CRC bytes go out.
// A small request queue sits between the classifier and the serializer, so
// new requests are taken while a frame is still being sent; s_axis_tready
// drops only when that queue is full.
// When the receiver stalls, the current byte holds and serialization pauses.
// Reset empties the queue and restarts at the first frame byte.
module modbus_read_request_framer
  import mrrf_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] device_address, [9:8] measure_kind, rest zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] frame_byte
  output logic        m_axis_tlast    // last_byte
);

  logic req_valid;
  logic req_ready;
  req_t req;

  mrrf_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .dev_addr_i    (s_axis_tdata[7:0]),
    .measure_kind_i(s_axis_tdata[9:8]),
    .req_valid_o   (req_valid),
    .req_ready_i   (req_ready),
    .req_o         (req)
  );

  mrrf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid),
    .req_ready_o(req_ready),
    .req_i      (req),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

endmodule

>>> tb/sv/modbus_read_request_checker.sv
`timescale 1ns / 1ps

module modbus_read_request_checker
  import mrrf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] device_address, [9:8] measure_kind
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // [7:0] frame_byte
  input  logic        m_axis_tlast,   // last_byte
  output int          mismatch_count_o,
  output int          pending_bytes_o,
  output int          bytes_checked_o
);

  localparam int unsigned FRAME_BYTES = 8;
  localparam int unsigned MAX_REPORTS = 10;

  localparam logic [15:0] REG_POWER   = 16'h030A;
  localparam logic [15:0] REG_VOLTAGE = 16'h030E;
  localparam logic [15:0] REG_CURRENT = 16'h0309;
  localparam logic [15:0] REG_DEFAULT = 16'h0003;
  localparam logic [15:0] CNT_SINGLE  = 16'h0001;
  localparam logic [15:0] CNT_VOLTAGE = 16'h0003;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_byte_t;

  frame_byte_t expected_frame_q[$];

  // Builds the full request for one transfer and queues its bytes in send order.
  function automatic void queue_request_bytes(input logic [7:0] dev_addr, input kind_e kind);
    logic [7:0]  body [6];
    logic [15:0] reg_addr;
    logic [15:0] reg_count;
    logic [15:0] crc;
    frame_byte_t fb;
    case (kind)
      KIND_POWER: begin
        reg_addr  = REG_POWER;
        reg_count = CNT_SINGLE;
      end
      KIND_VOLTAGE: begin
        reg_addr  = REG_VOLTAGE;
        reg_count = CNT_VOLTAGE;
      end
      KIND_CURRENT: begin
        reg_addr  = REG_CURRENT;
        reg_count = CNT_SINGLE;
      end
      default: begin
        reg_addr  = REG_DEFAULT;
        reg_count = CNT_SINGLE;
      end
    endcase
    body[0] = dev_addr;
    body[1] = FUNC_READ_HOLDING;
    body[2] = reg_addr[15:8];
    body[3] = reg_addr[7:0];
    body[4] = reg_count[15:8];
    body[5] = reg_count[7:0];
    // CRC-16/Modbus, LSB-first shift
    crc = CRC_INIT;
    for (int i = 0; i < 6; i++) begin
      crc ^= {8'h00, body[i]};
      for (int b = 0; b < 8; b++) begin
        crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
    end
    for (int i = 0; i < FRAME_BYTES; i++) begin
      fb.frame_byte = (i < 6) ? body[i] : ((i == 6) ? crc[7:0] : crc[15:8]);
      fb.last_byte  = (i == FRAME_BYTES - 1);
      expected_frame_q.push_back(fb);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_byte_t exp_b;
    if (!rst_ni) begin
      expected_frame_q.delete();
      mismatch_count_o <= 0;
      pending_bytes_o  <= 0;
      bytes_checked_o  <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        queue_request_bytes(s_axis_tdata[7:0], kind_e'(s_axis_tdata[9:8]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        bytes_checked_o <= bytes_checked_o + 1;
        if (expected_frame_q.size() == 0) begin
          if (mismatch_count_o < MAX_REPORTS) begin
            $display("[%0t] unexpected output byte 0x%02h last=%0b", $realtime,
                     m_axis_tdata, m_axis_tlast);
          end
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          exp_b = expected_frame_q.pop_front();
          if (m_axis_tdata !== exp_b.frame_byte || m_axis_tlast !== exp_b.last_byte) begin
            if (mismatch_count_o < MAX_REPORTS) begin
              $display("[%0t] byte mismatch: frame_byte exp 0x%02h got 0x%02h, last exp %0b got %0b",
                       $realtime, exp_b.frame_byte, m_axis_tdata, exp_b.last_byte,
                       m_axis_tlast);
            end
            mismatch_count_o <= mismatch_count_o + 1;
          end
        end
      end
      pending_bytes_o <= expected_frame_q.size();
    end
  end

endmodule

>>> tb/sv/tb_modbus_read_request_framer.sv
`timescale 1ns / 1ps

module tb_modbus_read_request_framer;
  import mrrf_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 460;
  localparam int unsigned IDLE_LIMIT      = 2000;
  localparam int unsigned DRAIN_CYCLES    = 16;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // [7:0] device_address, [9:8] measure_kind, rest zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // [7:0] frame_byte
  logic        m_axis_tlast;         // last_byte

  int mismatch_count;
  int pending_bytes;
  int bytes_checked;
  int kind_sent [4];
  int unsigned idle_cycles;

  modbus_read_request_framer i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast
  );

  modbus_read_request_checker i_checker (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .mismatch_count_o(mismatch_count),
    .pending_bytes_o (pending_bytes),
    .bytes_checked_o (bytes_checked)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Mostly short idle runs, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 2);
    end else if (r < 95) begin
      return $urandom_range(3, 8);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned sender_gap();
    return ($urandom_range(0, 99) < 55) ? 0 : idle_len();
  endfunction

  // Receiver: alternating ready and stall runs, with occasional long ready stretches.
  int unsigned rx_left;
  bit          rx_stall;
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_stall = !rx_stall;
      if (rx_stall) begin
        rx_left = idle_len();
      end else begin
        rx_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 16);
      end
    end
    rx_left--;
    m_axis_tready <= !rx_stall;
  end

  // Watchdog: cycles without any transfer on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d bytes outstanding", IDLE_LIMIT,
               pending_bytes);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // tready is sampled at the falling edge, where everything is settled.
  task automatic send_request(input logic [7:0] dev_addr, input kind_e kind,
                              input int unsigned gap);
    logic ready_seen;
    s_axis_tdata  <= {6'b0, kind, dev_addr};
    s_axis_tvalid <= 1'b1;
    do begin
      @(negedge clk_i);
      ready_seen = s_axis_tready;
      @(posedge clk_i);
    end while (!ready_seen);
    kind_sent[kind]++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // One edge first so the count includes a request accepted at this edge.
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_bytes != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0] corner_addr [6];
    int         total;
    corner_addr = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h5A, 8'hA5};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Address extremes against every measurement kind, bit patterns against one kind each
    foreach (corner_addr[a]) begin
      for (int k = 0; k < 4; k++) begin
        if (a < 2 || k == a - 2) begin
          send_request(corner_addr[a], kind_e'(k), (k == 3) ? sender_gap() : 0);
        end
      end
    end
    send_request(8'hFF, KIND_DEFAULT, 0);
    send_request(8'h00, KIND_VOLTAGE, 0);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == 150 || i == 330) begin
        wait_for_drain();
      end
      send_request(8'($urandom_range(0, 255)), kind_e'($urandom_range(0, 3)),
                   ((i / 40) % 4 == 1) ? 0 : sender_gap());
    end
    s_axis_tvalid <= 1'b0;

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    total = kind_sent[KIND_POWER] + kind_sent[KIND_VOLTAGE] + kind_sent[KIND_CURRENT] +
            kind_sent[KIND_DEFAULT];
    $display("Covered %0d requests (power %0d, voltage %0d, current %0d, default %0d)",
             total, kind_sent[KIND_POWER], kind_sent[KIND_VOLTAGE],
             kind_sent[KIND_CURRENT], kind_sent[KIND_DEFAULT]);
    $display("%0d frame bytes checked under random source gaps and sink stalls, %0d mismatches",
             bytes_checked, mismatch_count);
    if (pending_bytes != 0) begin
      $display("%0d expected bytes never arrived", pending_bytes);
    end
    if (mismatch_count == 0 && pending_bytes == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
